>>> hw/rtl/jse_pkg.sv
`timescale 1ns / 1ps
// jse_pkg: shared types, character codes and escape tables for the json string escaper
// no dependencies; used by jse_front, jse_back and json_string_escaper

package jse_pkg;

    // configuration register indexes
    localparam logic CFG_CAPACITY = 1'b0;
    localparam logic CFG_MEASURE  = 1'b1;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_UP_A   = 8'h41;

    localparam logic [2:0] LEN_PLAIN = 3'd1;
    localparam logic [2:0] LEN_SHORT = 3'd2;
    localparam logic [2:0] LEN_HEX   = 3'd6;

    // one classified byte as it travels from front to back
    typedef struct packed {
        logic [7:0] raw;
        logic [2:0] len;
        logic       emit;
        logic       trunc;
    } t_esc;

    localparam int ESC_W = $bits(t_esc);

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] d;
        d = (v < 4'd10) ? (CH_ZERO + {4'd0, v}) : (CH_UP_A + {4'd0, v} - 8'd10);
        return d;
    endfunction

    function automatic logic [2:0] esc_len(input logic [7:0] b);
        logic [2:0] n;
        case (b)
            CH_QUOTE, CH_BSLASH, CH_BS, CH_FF, CH_LF, CH_CR, CH_TAB: n = LEN_SHORT;
            default: n = (b >= CH_SPACE) ? LEN_PLAIN : LEN_HEX;
        endcase
        return n;
    endfunction

    // second byte of a two-byte escape
    function automatic logic [7:0] short_code(input logic [7:0] b);
        logic [7:0] c;
        case (b)
            CH_BS:   c = CH_LOW_B;
            CH_FF:   c = CH_LOW_F;
            CH_LF:   c = CH_LOW_N;
            CH_CR:   c = CH_LOW_R;
            CH_TAB:  c = CH_LOW_T;
            default: c = b;
        endcase
        return c;
    endfunction

    // byte at position idx of the escape of b
    function automatic logic [7:0] esc_byte(input logic [7:0] b, input logic [2:0] len,
                                            input logic [2:0] idx);
        logic [7:0] o;
        if (len == LEN_PLAIN) begin
            o = b;
        end else if (len == LEN_SHORT) begin
            o = (idx == 3'd0) ? CH_BSLASH : short_code(b);
        end else begin
            case (idx)
                3'd0:    o = CH_BSLASH;
                3'd1:    o = CH_LOW_U;
                3'd2:    o = CH_ZERO;
                3'd3:    o = CH_ZERO;
                3'd4:    o = hex_digit(b[7:4]);
                default: o = hex_digit(b[3:0]);
            endcase
        end
        return o;
    endfunction

endpackage

>>> hw/rtl/jse_if.sv
`timescale 1ns / 1ps
// jse_if: valid/ready channel interfaces for input bytes, result beats and config writes
// no dependencies

interface jse_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_string;
    modport source (output valid, output in_byte, output end_of_string, input ready);
    modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface jse_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        run_last;
    logic [31:0] used_count;
    logic        truncated;
    modport source (output valid, output out_byte, output byte_valid, output run_last,
                    output used_count, output truncated, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input run_last,
                    input used_count, input truncated, output ready);
endinterface

interface jse_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/jse_front.sv
`timescale 1ns / 1ps
// jse_front: config registers, byte classification, capacity check and position tracking
// depends on jse_pkg and jse_if

module jse_front #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    jse_in_if.sink                          i_in,
    jse_cfg_if.sink                         i_cfg,
    input  logic                            i_q_ready,
    output logic                            o_q_valid,
    output logic [COUNT_WIDTH+jse_pkg::ESC_W-1:0] o_q_data
);

    localparam int CW = COUNT_WIDTH;
    localparam int WW = ((CW > 32) ? CW : 32) + 1;

    logic [31:0]   r_capacity;
    logic          r_measure;
    logic [CW-1:0] r_pos, n_pos;
    logic          r_stop, n_stop;

    logic [2:0]    len;
    logic [WW-1:0] sum_w, cap_w, max_w, capm_w;
    logic          fits;
    logic [CW-1:0] count;
    jse_pkg::t_esc esc;
    logic          take;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = i_q_ready;
    assign o_q_valid   = i_in.valid;
    assign take        = i_in.valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= 32'd0;
            r_measure  <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                jse_pkg::CFG_CAPACITY: r_capacity <= i_cfg.data;
                jse_pkg::CFG_MEASURE:  r_measure  <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        len    = jse_pkg::esc_len(i_in.in_byte);
        sum_w  = WW'(r_pos) + WW'(len);
        cap_w  = WW'(r_capacity);
        max_w  = WW'({CW{1'b1}});
        capm_w = (cap_w < max_w) ? cap_w : max_w;
        fits   = (sum_w <= capm_w);

        n_pos     = r_pos;
        n_stop    = r_stop;
        esc.raw   = i_in.in_byte;
        esc.len   = len;
        esc.emit  = 1'b0;
        esc.trunc = 1'b1;
        count     = r_pos;
        if (r_measure) begin
            // saturating length count
            n_pos     = (sum_w > max_w) ? {CW{1'b1}} : sum_w[CW-1:0];
            esc.trunc = r_stop;
            count     = n_pos;
        end else if (!r_stop) begin
            if (fits) begin
                n_pos     = sum_w[CW-1:0];
                esc.emit  = 1'b1;
                esc.trunc = 1'b0;
                count     = r_pos + CW'(1);
            end else begin
                n_stop = 1'b1;
            end
        end
        if (i_in.end_of_string) begin
            n_pos  = '0;
            n_stop = 1'b0;
        end
    end

    assign o_q_data = {count, esc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_stop <= 1'b0;
        end else if (take) begin
            r_pos  <= n_pos;
            r_stop <= n_stop;
        end
    end

endmodule

>>> hw/rtl/jse_fifo.sv
`timescale 1ns / 1ps
// jse_fifo: small show-ahead queue of classified bytes between front and back
// no dependencies

module jse_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_ready,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [AW-1:0]     r_wr, r_rd;
    logic [CNT_W-1:0]  r_cnt;
    logic              do_push, do_pop;

    assign o_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

>>> hw/rtl/jse_back.sv
`timescale 1ns / 1ps
// jse_back: expands each classified byte into its result beats through an output register
// depends on jse_pkg and jse_if

module jse_back #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_valid,
    input  logic [COUNT_WIDTH+jse_pkg::ESC_W-1:0] i_q_data,
    output logic                            o_q_pop,
    jse_out_if.source                       o_out
);

    localparam int CW = COUNT_WIDTH;
    localparam int SW = (CW > 32) ? CW : 32;

    jse_pkg::t_esc esc;
    logic [CW-1:0] base;
    logic [2:0]    r_idx;
    logic          take, last;
    logic [SW-1:0] wide;
    logic [31:0]   shown;
    logic [7:0]    obyte;

    logic          r_ov;
    logic [7:0]    r_byte;
    logic          r_bv, r_last, r_trunc;
    logic [31:0]   r_used;

    assign esc  = jse_pkg::t_esc'(i_q_data[jse_pkg::ESC_W-1:0]);
    assign base = i_q_data[CW+jse_pkg::ESC_W-1:jse_pkg::ESC_W];

    always_comb begin
        take  = i_q_valid && (!r_ov || o_out.ready);
        last  = !esc.emit || (r_idx == esc.len - 3'd1);
        obyte = esc.emit ? jse_pkg::esc_byte(esc.raw, esc.len, r_idx) : 8'd0;
        // count shown on this beat, held at the 32-bit maximum
        wide  = esc.emit ? SW'(base + CW'(r_idx)) : SW'(base);
        shown = (wide > SW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : wide[31:0];
    end

    assign o_q_pop = take && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_idx <= 3'd0;
        end else begin
            if (take) begin
                r_ov  <= 1'b1;
                r_idx <= last ? 3'd0 : r_idx + 3'd1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_byte  <= obyte;
            r_bv    <= esc.emit;
            r_last  <= last;
            r_trunc <= esc.trunc;
            r_used  <= shown;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.out_byte   = r_byte;
    assign o_out.byte_valid = r_bv;
    assign o_out.run_last   = r_last;
    assign o_out.used_count = r_used;
    assign o_out.truncated  = r_trunc;

endmodule

>>> hw/rtl/json_string_escaper.sv
`timescale 1ns / 1ps
// json_string_escaper: top level joining front, byte queue and back
// depends on jse_pkg, jse_if, jse_front, jse_fifo, jse_back
//
//  port    dir   beat carries
//  i_in    in    in_byte, end_of_string
//  o_out   out   out_byte, byte_valid, run_last, used_count, truncated
//  i_cfg   in    index (0 capacity, 1 measure mode), data
//
// a plain byte gives one result beat, a short escape two, a \u00XX escape six;
// the back emits one beat per cycle while o_out is ready, so sustained rate is one byte
// per cycle for printable text; an escaped byte holds the back until all its beats are out.
// the front takes a byte every cycle while the four-entry queue has room.
// synchronous active-low reset clears position, stop flag, registers and queue.
// o_out is registered: a stalled sink holds the beat while the front keeps filling.

module json_string_escaper #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    jse_in_if.sink     i_in,
    jse_cfg_if.sink    i_cfg,
    jse_out_if.source  o_out
);

    localparam int QW = COUNT_WIDTH + jse_pkg::ESC_W;

    logic          push_valid, push_ready;
    logic [QW-1:0] push_data;
    logic          head_valid, pop;
    logic [QW-1:0] head_data;

    jse_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_cfg     (i_cfg),
        .i_q_ready (push_ready),
        .o_q_valid (push_valid),
        .o_q_data  (push_data)
    );

    jse_fifo #(.DATA_W(QW), .DEPTH(4)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_valid),
        .i_data  (push_data),
        .o_ready (push_ready),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_data  (head_data)
    );

    jse_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (head_valid),
        .i_q_data  (head_data),
        .o_q_pop   (pop),
        .o_out     (o_out)
    );

    // a real output byte never comes from a stopped string
    a_valid_not_trunc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.byte_valid |-> !o_out.truncated)
        else $error("valid byte flagged truncated");

    // an empty beat is always the only beat of its byte
    a_invalid_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.byte_valid |-> o_out.run_last)
        else $error("empty beat not last");

    // input is refused only while the queue is full, so never while it is empty
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> head_valid)
        else $error("input stalled with empty queue");

endmodule

>>> sim/jse_escape_check.sv
`timescale 1ns / 1ps
// jse_escape_check: watches the byte, config and result channels of the json string escaper,
// predicts the escaped result beats and compares them in order
// depends on jse_pkg and jse_if

module jse_escape_check (
    input  logic i_clk,
    input  logic i_rst_n,
    jse_in_if    in_ch,
    jse_cfg_if   cfg_ch,
    jse_out_if   out_ch,
    output int   o_fail_count,
    output int   o_pending
);

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
    localparam logic [3:0]  DEC_LIMIT = 4'd10;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        run_last;
        logic [31:0] used_count;
        logic        truncated;
    } t_result;

    t_result     escaped_q[$];
    t_result     want;
    logic [31:0] capacity;
    logic        measure;
    logic [31:0] position;
    logic        stopped;
    int          fails = 0;

    function automatic logic [7:0] nibble_char(input logic [3:0] v);
        logic [7:0] c;
        if (v < DEC_LIMIT) begin
            c = jse_pkg::CH_ZERO + {4'd0, v};
        end else begin
            c = jse_pkg::CH_UP_A + {4'd0, v - DEC_LIMIT};
        end
        return c;
    endfunction

    // escape sequence of one byte, first byte in seq[0]; returns its length
    function automatic logic [2:0] escape_seq(input logic [7:0] b, output logic [5:0][7:0] seq);
        logic [2:0] n;
        seq = '0;
        seq[0] = jse_pkg::CH_BSLASH;
        n = jse_pkg::LEN_SHORT;
        case (b)
            jse_pkg::CH_QUOTE, jse_pkg::CH_BSLASH: seq[1] = b;
            jse_pkg::CH_BS:  seq[1] = jse_pkg::CH_LOW_B;
            jse_pkg::CH_FF:  seq[1] = jse_pkg::CH_LOW_F;
            jse_pkg::CH_LF:  seq[1] = jse_pkg::CH_LOW_N;
            jse_pkg::CH_CR:  seq[1] = jse_pkg::CH_LOW_R;
            jse_pkg::CH_TAB: seq[1] = jse_pkg::CH_LOW_T;
            default: begin
                if (b >= jse_pkg::CH_SPACE) begin
                    seq[0] = b;
                    n = jse_pkg::LEN_PLAIN;
                end else begin
                    seq[1] = jse_pkg::CH_LOW_U;
                    seq[2] = jse_pkg::CH_ZERO;
                    seq[3] = jse_pkg::CH_ZERO;
                    seq[4] = nibble_char(b[7:4]);
                    seq[5] = nibble_char(b[3:0]);
                    n = jse_pkg::LEN_HEX;
                end
            end
        endcase
        return n;
    endfunction

    function automatic t_result make_result(input logic [7:0] b, input logic ok,
                                            input logic last);
        t_result r;
        r.out_byte   = b;
        r.byte_valid = ok;
        r.run_last   = last;
        r.used_count = position;
        r.truncated  = stopped;
        return r;
    endfunction

    task automatic predict_escape(input logic [7:0] b, input logic eos);
        logic [5:0][7:0] seq;
        logic [2:0]      n;
        logic [31:0]     n32;
        n = escape_seq(b, seq);
        n32 = {29'd0, n};
        if (measure) begin
            // length count saturates
            if (position > COUNT_MAX - n32) begin
                position = COUNT_MAX;
            end else begin
                position = position + n32;
            end
            escaped_q.push_back(make_result(8'h00, 1'b0, 1'b1));
        end else if (stopped) begin
            escaped_q.push_back(make_result(8'h00, 1'b0, 1'b1));
        end else if (n32 > capacity || position > capacity - n32) begin
            stopped = 1'b1;
            escaped_q.push_back(make_result(8'h00, 1'b0, 1'b1));
        end else begin
            for (int i = 0; i < n; i++) begin
                position = position + 32'd1;
                escaped_q.push_back(make_result(seq[i], 1'b1, i == n - 1));
            end
        end
        if (eos) begin
            position = '0;
            stopped  = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            capacity = '0;
            measure  = 1'b0;
            position = '0;
            stopped  = 1'b0;
            escaped_q.delete();
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    jse_pkg::CFG_CAPACITY: capacity = cfg_ch.data;
                    jse_pkg::CFG_MEASURE:  measure  = cfg_ch.data[0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                predict_escape(in_ch.in_byte, in_ch.end_of_string);
            end
            if (out_ch.valid && out_ch.ready) begin
                if (escaped_q.size() == 0) begin
                    $error("result beat with nothing expected: out_byte %0h", out_ch.out_byte);
                    fails++;
                end else begin
                    want = escaped_q.pop_front();
                    if (out_ch.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %0h, got %0h", want.out_byte, out_ch.out_byte);
                        fails++;
                    end
                    if (out_ch.byte_valid !== want.byte_valid) begin
                        $error("byte_valid: expected %0b, got %0b", want.byte_valid,
                               out_ch.byte_valid);
                        fails++;
                    end
                    if (out_ch.run_last !== want.run_last) begin
                        $error("run_last: expected %0b, got %0b", want.run_last, out_ch.run_last);
                        fails++;
                    end
                    if (out_ch.used_count !== want.used_count) begin
                        $error("used_count: expected %0d, got %0d", want.used_count,
                               out_ch.used_count);
                        fails++;
                    end
                    if (out_ch.truncated !== want.truncated) begin
                        $error("truncated: expected %0b, got %0b", want.truncated,
                               out_ch.truncated);
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= escaped_q.size();
    end

endmodule

>>> sim/tb_json_string_escaper.sv
`timescale 1ns / 1ps
// tb_json_string_escaper: drives strings and register writes into the json string escaper
// depends on jse_pkg, jse_if, json_string_escaper and jse_escape_check

module tb_json_string_escaper;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   pending;
    int   fail_count;
    int   burst_left = 0;
    int   items_sent = 0;

    jse_in_if  in_ch ();
    jse_cfg_if cfg_ch ();
    jse_out_if out_ch ();

    json_string_escaper dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .i_cfg  (cfg_ch),
        .o_out  (out_ch)
    );

    jse_escape_check escape_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_ch       (in_ch),
        .cfg_ch      (cfg_ch),
        .out_ch      (out_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // result side stalls in runs of its own, now and then long ones
    initial begin
        int run_left;
        int stall_left;
        run_left = 0;
        stall_left = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (run_left == 0 && stall_left == 0) begin
                run_left = $urandom_range(1, 40);
                stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 15)
                                                        : $urandom_range(0, 3);
            end
            if (run_left > 0) begin
                out_ch.ready <= 1'b1;
                run_left--;
            end else begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eos);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        in_ch.valid         <= 1'b1;
        in_ch.in_byte       <= b;
        in_ch.end_of_string <= eos;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    // stop sending and wait until every expected beat has come back
    task automatic settle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic apply_config(input logic [31:0] cap, input logic meas);
        settle();
        write_reg(jse_pkg::CFG_CAPACITY, cap);
        write_reg(jse_pkg::CFG_MEASURE, {31'd0, meas});
    endtask

    function automatic logic [7:0] pick_byte();
        logic [7:0] b;
        case ($urandom_range(0, 4))
            0, 1: b = 8'($urandom_range(8'h20, 8'h7E));
            2: begin
                case ($urandom_range(0, 7))
                    0: b = jse_pkg::CH_QUOTE;
                    1: b = jse_pkg::CH_BSLASH;
                    2: b = jse_pkg::CH_BS;
                    3: b = jse_pkg::CH_FF;
                    4: b = jse_pkg::CH_LF;
                    5: b = jse_pkg::CH_CR;
                    6: b = jse_pkg::CH_TAB;
                    default: b = 8'h2F;
                endcase
            end
            3: b = 8'($urandom_range(0, 31));
            default: b = 8'($urandom_range(0, 255));
        endcase
        return b;
    endfunction

    task automatic send_string(input int len, input bit leave_open);
        for (int k = 0; k < len; k++) begin
            send_byte(pick_byte(), (k == len - 1) && !leave_open);
        end
    endtask

    function automatic logic [31:0] pick_capacity();
        logic [31:0] c;
        case ($urandom_range(0, 6))
            0: c = 32'd0;
            1: c = 32'hFFFF_FFFF;
            2: c = $urandom;
            default: c = $urandom_range(1, 30);
        endcase
        return c;
    endfunction

    initial begin
        logic [7:0] edge_bytes [14];
        int         phase_items;
        int         phase_goal;
        edge_bytes = '{jse_pkg::CH_QUOTE, jse_pkg::CH_BSLASH, jse_pkg::CH_BS, jse_pkg::CH_FF,
                       jse_pkg::CH_LF, jse_pkg::CH_CR, jse_pkg::CH_TAB,
                       8'h00, 8'h1F, 8'h1A, jse_pkg::CH_SPACE, 8'h2F, 8'h7F, 8'hFF};
        in_ch.valid         = 1'b0;
        in_ch.in_byte       = '0;
        in_ch.end_of_string = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = jse_pkg::CFG_CAPACITY;
        cfg_ch.data         = '0;
        i_rst_n             = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // every escape class with unlimited room
        apply_config(32'hFFFF_FFFF, 1'b0);
        foreach (edge_bytes[k]) send_byte(edge_bytes[k], k == 13);

        // no room at all: first byte stops, next is already stopped
        apply_config(32'd0, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(jse_pkg::CH_QUOTE, 1'b1);

        // exact fit, then the first byte past the end
        apply_config(32'd3, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(jse_pkg::CH_LF, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(8'h63, 1'b1);

        // capacity raised inside a string
        apply_config(32'd1, 1'b0);
        send_byte(8'h78, 1'b0);
        settle();
        write_reg(jse_pkg::CFG_CAPACITY, 32'd3);
        send_byte(jse_pkg::CH_QUOTE, 1'b1);

        // mode switched inside a string, stop flag carried into measure mode
        apply_config(32'd0, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h71, 1'b0);
        settle();
        write_reg(jse_pkg::CFG_MEASURE, 32'd0);
        send_byte(8'h7A, 1'b0);
        settle();
        write_reg(jse_pkg::CFG_MEASURE, 32'd1);
        send_byte(jse_pkg::CH_LF, 1'b1);

        items_sent = 0;
        while (items_sent < 150) begin
            apply_config(pick_capacity(), $urandom_range(0, 3) == 0);
            phase_items = items_sent;
            phase_goal = $urandom_range(15, 35);
            while (items_sent - phase_items < phase_goal) begin
                send_string($urandom_range(1, 12),
                            (items_sent - phase_items >= phase_goal - 12) &&
                            ($urandom_range(0, 3) == 0));
            end
        end

        settle();
        repeat (16) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_json_string_escaper passed");
        end else begin
            $display("tb_json_string_escaper failed");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("tb_json_string_escaper failed");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/jse_pkg.sv
hw/rtl/jse_if.sv
hw/rtl/jse_front.sv
hw/rtl/jse_fifo.sv
hw/rtl/jse_back.sv
hw/rtl/json_string_escaper.sv
sim/jse_escape_check.sv
sim/tb_json_string_escaper.sv
